// ===== design/dptf_pkg.sv =====
// ----------------------------------------------------------------------------
// Depth point transform filter package
// Shared widths, register indexes, fixed-point limits and the pipeline
// control bundle used by the datapath modules.
// ----------------------------------------------------------------------------
`default_nettype none

package dptf_pkg;

    // Field and register widths.
    localparam int unsigned COORD_W   = 32;
    localparam int unsigned COEF_W    = 18;
    localparam int unsigned ROW_W     = 3 * COEF_W;
    localparam int unsigned CHAN_W    = 8;
    localparam int unsigned COLOR_W   = 3 * CHAN_W;
    localparam int unsigned CLASS_W   = 8;
    localparam int unsigned CFG_IDX_W = 3;
    localparam int unsigned CFG_DATA_W = ROW_W;

    // Product of an 18-bit coefficient and a 32-bit coordinate, its value
    // after rounding to Q16.16, and the exact sum of three of them plus a shift.
    localparam int unsigned PROD_W = COEF_W + COORD_W;
    localparam int unsigned FRAC_W = 16;
    localparam int unsigned RND_W  = PROD_W - FRAC_W;
    localparam int unsigned SUM_W  = RND_W + 2;

    // Rounding offset: half of one Q16.16 unit.
    localparam logic signed [PROD_W-1:0] ROUND_HALF = PROD_W'(1) << (FRAC_W - 1);

    // Depth gate limits, 1.0 m and 80.0 m in Q16.16.
    localparam logic signed [COORD_W-1:0] DEPTH_MIN = 32'sd65536;
    localparam logic signed [COORD_W-1:0] DEPTH_MAX = 32'sd5242880;

    // Saturation bounds of the signed 32-bit result.
    localparam logic signed [SUM_W-1:0] SAT_MAX = 36'sd2147483647;
    localparam logic signed [SUM_W-1:0] SAT_MIN = -36'sd2147483648;

    // Class reported when semantics are disabled.
    localparam logic [CLASS_W-1:0] NO_CLASS = 8'd255;

    // Register reset values: identity rotation, one coefficient per row.
    localparam logic [ROW_W-1:0] ROW0_RST = ROW_W'(65536);
    localparam logic [ROW_W-1:0] ROW1_RST = ROW_W'(65536) << COEF_W;
    localparam logic [ROW_W-1:0] ROW2_RST = ROW_W'(65536) << (2 * COEF_W);

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ROT_ROW0     = 3'd0,
        CFG_ROT_ROW1     = 3'd1,
        CFG_ROT_ROW2     = 3'd2,
        CFG_SHIFT_X      = 3'd3,
        CFG_SHIFT_Y      = 3'd4,
        CFG_SHIFT_Z      = 3'd5,
        CFG_SEMANTICS_ON = 3'd6
    } t_cfg_idx;

    // Load enables of the product and result stages.
    typedef struct packed {
        logic ld_prod;
        logic ld_out;
    } t_stage_ctrl;

endpackage

`default_nettype wire

// ===== design/dptf_in_stage.sv =====
// ----------------------------------------------------------------------------
// Input stage
// Applies the depth gate to an incoming pixel and registers its fields.
// ----------------------------------------------------------------------------
`default_nettype none

module dptf_in_stage (
    input  wire logic                                 i_clk,
    input  wire logic                                 i_load,
    input  wire logic signed [dptf_pkg::COORD_W-1:0]  i_cam_x,
    input  wire logic signed [dptf_pkg::COORD_W-1:0]  i_cam_y,
    input  wire logic signed [dptf_pkg::COORD_W-1:0]  i_cam_z,
    input  wire logic        [dptf_pkg::CHAN_W-1:0]   i_blue,
    input  wire logic        [dptf_pkg::CHAN_W-1:0]   i_green,
    input  wire logic        [dptf_pkg::CHAN_W-1:0]   i_red,
    input  wire logic        [dptf_pkg::CLASS_W-1:0]  i_class_in,
    output logic                                      o_pass,
    output logic signed      [dptf_pkg::COORD_W-1:0]  o_x,
    output logic signed      [dptf_pkg::COORD_W-1:0]  o_y,
    output logic signed      [dptf_pkg::COORD_W-1:0]  o_z,
    output logic             [dptf_pkg::COLOR_W-1:0]  o_color,
    output logic             [dptf_pkg::CLASS_W-1:0]  o_class
);
    import dptf_pkg::*;

    logic signed [COORD_W-1:0] r_x;
    logic signed [COORD_W-1:0] r_y;
    logic signed [COORD_W-1:0] r_z;
    logic        [COLOR_W-1:0] r_color;
    logic        [CLASS_W-1:0] r_class;

    // A pixel is kept only when its depth lies within the closed range.
    assign o_pass = (i_cam_z >= DEPTH_MIN) && (i_cam_z <= DEPTH_MAX);

    // Payload register; the colour is packed as red, green, blue.
    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_x     <= i_cam_x;
            r_y     <= i_cam_y;
            r_z     <= i_cam_z;
            r_color <= {i_red, i_green, i_blue};
            r_class <= i_class_in;
        end
    end

    assign o_x     = r_x;
    assign o_y     = r_y;
    assign o_z     = r_z;
    assign o_color = r_color;
    assign o_class = r_class;

endmodule

`default_nettype wire

// ===== design/dptf_row_unit.sv =====
// ----------------------------------------------------------------------------
// Row unit
// One row of the rigid transform: three rounded products, then their sum
// with the translation, saturated to 32 bits.
// ----------------------------------------------------------------------------
`default_nettype none

module dptf_row_unit (
    input  wire logic                                 i_clk,
    input  wire dptf_pkg::t_stage_ctrl                i_ctrl,
    input  wire logic        [dptf_pkg::ROW_W-1:0]    i_row,
    input  wire logic signed [dptf_pkg::COORD_W-1:0]  i_shift,
    input  wire logic signed [dptf_pkg::COORD_W-1:0]  i_x,
    input  wire logic signed [dptf_pkg::COORD_W-1:0]  i_y,
    input  wire logic signed [dptf_pkg::COORD_W-1:0]  i_z,
    output logic signed      [dptf_pkg::COORD_W-1:0]  o_world
);
    import dptf_pkg::*;

    logic signed [COEF_W-1:0]  w_c0;
    logic signed [COEF_W-1:0]  w_c1;
    logic signed [COEF_W-1:0]  w_c2;
    logic signed [PROD_W-1:0]  w_p0;
    logic signed [PROD_W-1:0]  w_p1;
    logic signed [PROD_W-1:0]  w_p2;
    logic signed [PROD_W-1:0]  w_q0;
    logic signed [PROD_W-1:0]  w_q1;
    logic signed [PROD_W-1:0]  w_q2;
    logic signed [RND_W-1:0]   r_rnd0;
    logic signed [RND_W-1:0]   r_rnd1;
    logic signed [RND_W-1:0]   r_rnd2;
    logic signed [SUM_W-1:0]   w_sum;
    logic signed [COORD_W-1:0] n_world;
    logic signed [COORD_W-1:0] r_world;

    // Coefficients of this row, column 0 in the lowest bits.
    assign w_c0 = i_row[COEF_W-1:0];
    assign w_c1 = i_row[2*COEF_W-1:COEF_W];
    assign w_c2 = i_row[3*COEF_W-1:2*COEF_W];

    // Exact products, then half a unit added so that the floor rounds to nearest.
    assign w_p0 = w_c0 * i_x;
    assign w_p1 = w_c1 * i_y;
    assign w_p2 = w_c2 * i_z;
    assign w_q0 = w_p0 + ROUND_HALF;
    assign w_q1 = w_p1 + ROUND_HALF;
    assign w_q2 = w_p2 + ROUND_HALF;

    // Product register holds the rounded Q16.16 terms.
    always_ff @(posedge i_clk) begin
        if (i_ctrl.ld_prod) begin
            r_rnd0 <= w_q0[PROD_W-1:FRAC_W];
            r_rnd1 <= w_q1[PROD_W-1:FRAC_W];
            r_rnd2 <= w_q2[PROD_W-1:FRAC_W];
        end
    end

    // Exact sum of the terms and the translation, clamped to 32 bits.
    assign w_sum = SUM_W'(i_shift) + SUM_W'(r_rnd0) + SUM_W'(r_rnd1) + SUM_W'(r_rnd2);

    always_comb begin
        if (w_sum > SAT_MAX) begin
            n_world = SAT_MAX[COORD_W-1:0];
        end else if (w_sum < SAT_MIN) begin
            n_world = SAT_MIN[COORD_W-1:0];
        end else begin
            n_world = w_sum[COORD_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.ld_out) begin
            r_world <= n_world;
        end
    end

    assign o_world = r_world;

endmodule

`default_nettype wire

// ===== design/depth_point_transform_filter.sv =====
// A kept pixel reaches the outputs through the input, product and result registers
// after its transaction is accepted; a pixel outside the depth gate gives none.
// Throughput: one pixel per cycle, set by the three register stages that all
// advance together whenever the output is not stalled.
// Reset: synchronous, active low; clears the stage valid bits and loads the
// identity rotation, zero translation and semantics disabled.
// ----------------------------------------------------------------------------
// Depth point transform filter
// Gates camera points on depth, applies a configured rigid transform and
// emits the world point with its packed colour and semantic class.
// ----------------------------------------------------------------------------
`default_nettype none

module depth_point_transform_filter (
    input  wire logic                                    i_clk,
    input  wire logic                                    i_rst_n,
    // Pixel input channel
    input  wire logic                                    i_valid,
    output logic                                         o_stall,
    input  wire logic signed [dptf_pkg::COORD_W-1:0]     i_cam_x,
    input  wire logic signed [dptf_pkg::COORD_W-1:0]     i_cam_y,
    input  wire logic signed [dptf_pkg::COORD_W-1:0]     i_cam_z,
    input  wire logic        [dptf_pkg::CHAN_W-1:0]      i_blue,
    input  wire logic        [dptf_pkg::CHAN_W-1:0]      i_green,
    input  wire logic        [dptf_pkg::CHAN_W-1:0]      i_red,
    input  wire logic        [dptf_pkg::CLASS_W-1:0]     i_class_in,
    // Result output channel
    output logic                                         o_valid,
    input  wire logic                                    i_stall,
    output logic signed      [dptf_pkg::COORD_W-1:0]     o_world_x,
    output logic signed      [dptf_pkg::COORD_W-1:0]     o_world_y,
    output logic signed      [dptf_pkg::COORD_W-1:0]     o_world_z,
    output logic             [dptf_pkg::COLOR_W-1:0]     o_packed_color,
    output logic             [dptf_pkg::CLASS_W-1:0]     o_class_out,
    // Configuration write channel
    input  wire logic                                    i_cfg_valid,
    output logic                                         o_cfg_ready,
    input  wire logic        [dptf_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  wire logic        [dptf_pkg::CFG_DATA_W-1:0]  i_cfg_data
);
    import dptf_pkg::*;

    // Configuration registers
    logic        [ROW_W-1:0]   r_rot_row0;
    logic        [ROW_W-1:0]   r_rot_row1;
    logic        [ROW_W-1:0]   r_rot_row2;
    logic signed [COORD_W-1:0] r_shift_x;
    logic signed [COORD_W-1:0] r_shift_y;
    logic signed [COORD_W-1:0] r_shift_z;
    logic                      r_semantics_on;

    // Stage valid bits and handshake
    logic        r_v1;
    logic        r_v2;
    logic        r_vo;
    logic        w_ld1;
    logic        w_accept;
    logic        w_pass;
    t_stage_ctrl w_ctrl;

    // Stage one outputs
    logic signed [COORD_W-1:0] w_x;
    logic signed [COORD_W-1:0] w_y;
    logic signed [COORD_W-1:0] w_z;
    logic        [COLOR_W-1:0] w_color;
    logic        [CLASS_W-1:0] w_class;

    // Side payload carried alongside the arithmetic
    logic [COLOR_W-1:0] r_color2;
    logic [CLASS_W-1:0] r_class2;
    logic [COLOR_W-1:0] r_color_o;
    logic [CLASS_W-1:0] r_class_o;

    // Configuration writes are always taken; unknown indexes are dropped.
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rot_row0     <= ROW0_RST;
            r_rot_row1     <= ROW1_RST;
            r_rot_row2     <= ROW2_RST;
            r_shift_x      <= '0;
            r_shift_y      <= '0;
            r_shift_z      <= '0;
            r_semantics_on <= 1'b0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (t_cfg_idx'(i_cfg_index))
                CFG_ROT_ROW0:     r_rot_row0     <= i_cfg_data;
                CFG_ROT_ROW1:     r_rot_row1     <= i_cfg_data;
                CFG_ROT_ROW2:     r_rot_row2     <= i_cfg_data;
                CFG_SHIFT_X:      r_shift_x      <= i_cfg_data[COORD_W-1:0];
                CFG_SHIFT_Y:      r_shift_y      <= i_cfg_data[COORD_W-1:0];
                CFG_SHIFT_Z:      r_shift_z      <= i_cfg_data[COORD_W-1:0];
                CFG_SEMANTICS_ON: r_semantics_on <= i_cfg_data[0];
                default: begin
                end
            endcase
        end
    end

    // Each stage loads when it is empty or the stage after it moves on.
    assign w_ctrl.ld_out  = !r_vo || !i_stall;
    assign w_ctrl.ld_prod = !r_v2 || w_ctrl.ld_out;
    assign w_ld1          = !r_v1 || w_ctrl.ld_prod;
    assign o_stall        = !w_ld1;
    assign w_accept       = i_valid && w_ld1;

    // A pixel rejected by the depth gate is consumed but leaves a bubble.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_vo <= 1'b0;
        end else begin
            if (w_ld1) begin
                r_v1 <= i_valid && w_pass;
            end
            if (w_ctrl.ld_prod) begin
                r_v2 <= r_v1;
            end
            if (w_ctrl.ld_out) begin
                r_vo <= r_v2;
            end
        end
    end

    dptf_in_stage u_in_stage (
        .i_clk      (i_clk),
        .i_load     (w_ld1),
        .i_cam_x    (i_cam_x),
        .i_cam_y    (i_cam_y),
        .i_cam_z    (i_cam_z),
        .i_blue     (i_blue),
        .i_green    (i_green),
        .i_red      (i_red),
        .i_class_in (i_class_in),
        .o_pass     (w_pass),
        .o_x        (w_x),
        .o_y        (w_y),
        .o_z        (w_z),
        .o_color    (w_color),
        .o_class    (w_class)
    );

    dptf_row_unit u_row_x (
        .i_clk   (i_clk),
        .i_ctrl  (w_ctrl),
        .i_row   (r_rot_row0),
        .i_shift (r_shift_x),
        .i_x     (w_x),
        .i_y     (w_y),
        .i_z     (w_z),
        .o_world (o_world_x)
    );

    dptf_row_unit u_row_y (
        .i_clk   (i_clk),
        .i_ctrl  (w_ctrl),
        .i_row   (r_rot_row1),
        .i_shift (r_shift_y),
        .i_x     (w_x),
        .i_y     (w_y),
        .i_z     (w_z),
        .o_world (o_world_y)
    );

    dptf_row_unit u_row_z (
        .i_clk   (i_clk),
        .i_ctrl  (w_ctrl),
        .i_row   (r_rot_row2),
        .i_shift (r_shift_z),
        .i_x     (w_x),
        .i_y     (w_y),
        .i_z     (w_z),
        .o_world (o_world_z)
    );

    // Colour and class follow the arithmetic through the same stages.
    always_ff @(posedge i_clk) begin
        if (w_ctrl.ld_prod) begin
            r_color2 <= w_color;
            r_class2 <= r_semantics_on ? w_class : NO_CLASS;
        end
        if (w_ctrl.ld_out) begin
            r_color_o <= r_color2;
            r_class_o <= r_class2;
        end
    end

    assign o_valid        = r_vo;
    assign o_packed_color = r_color_o;
    assign o_class_out    = r_class_o;

    // The input is held off only when every stage is occupied and the output stalls.
    a_stall_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> (r_v1 && r_v2 && r_vo && i_stall))
        else $error("input stalled while the pipeline has room");

    // An accepted transaction fills stage one exactly when it passes the depth gate.
    a_gate: assert property (@(posedge i_clk)
        (i_rst_n && w_accept) |=> (r_v1 == $past(w_pass)))
        else $error("depth gate result not reflected in stage one");

    // A result only appears when the product stage held an item.
    a_out_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_valid) |-> $past(r_v2))
        else $error("result raised without a product stage item");

    // An empty output register always takes the item waiting behind it.
    a_no_bubble: assert property (@(posedge i_clk)
        (i_rst_n && r_v2 && !r_vo) |=> o_valid)
        else $error("product stage item not moved to the output");

endmodule

`default_nettype wire
